// ----- hw/rtl/blss_pkg.sv -----
package blss_pkg;

    // Widths of the stream fields, fixed by the request and result formats.
    localparam int OPC_W      = 3;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 8;
    localparam int LEN_W      = 9;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 64;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_COUNT = 3'd2,
        OP_FIND  = 3'd3,
        OP_FETCH = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  data_out;
        logic [LEN_W-1:0]   match_count;
        logic               found;
        logic [POS_W-1:0]   found_position;
        logic [LEN_W-1:0]   list_length;
    } result_t;

endpackage

// ----- hw/rtl/blss_ram.sv -----
module blss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/bounded_list_stack_search.sv -----
// Channel  Direction  Beat contents (lowest bit first)
// s_axis   in         tuser: opcode[2:0]; tdata: operand_value[31:0], position[39:32]
// m_axis   out        tdata: status[1:0], data_out[33:2], match_count[42:34],
//                            found[43], found_position[51:44], list_length[60:52]
//
// Steps: push, undecoded opcodes and failing requests go from the accept straight to
// the result state; pop and fetch first pass through one value memory read, and count
// and find read one entry per scan step; the input reopens once the result register
// is loaded, so a new beat is not accepted before the last one is through the scan.
// Reset clears the length and the handshake state, not the value memory.
// While a result waits on m_axis_tready one more beat is accepted; its result waits.
module bounded_list_stack_search #(
    parameter int LIST_DEPTH  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // opcode[2:0]
    input  logic [blss_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // operand_value[31:0], position[39:32]
    input  logic [blss_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status[1:0], data_out[33:2], match_count[42:34], found[43],
    // found_position[51:44], list_length[60:52], zero above
    output logic [blss_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import blss_pkg::*;

    // The count must hold the depth itself; the address only reaches depth - 1.
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int AW   = $clog2(LIST_DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t                 state_reg,     state_next;
    logic [CW-1:0]          count_reg,     count_next;
    logic [OPC_W-1:0]       op_reg,        op_next;
    logic [VALUE_WIDTH-1:0] val_reg,       val_next;
    logic [CW-1:0]          cmp_reg,       cmp_next;
    logic [CW-1:0]          mcnt_reg,      mcnt_next;
    result_t                res_reg,       res_next;
    result_t                out_reg,       out_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   accept;
    logic [OPC_W-1:0]       in_op;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [POS_W-1:0]       in_pos;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    logic [CW-1:0]          top_slot;
    logic [CW-1:0]          fetch_slot;
    logic [CW-1:0]          scan_slot;
    logic                   hit;
    logic                   last;
    logic                   out_free;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign in_op  = s_axis_tuser[OPC_W-1:0];
    assign in_val = VALUE_WIDTH'($signed(s_axis_tdata[DATA_W-1:0]));
    assign in_pos = s_axis_tdata[DATA_W +: POS_W];

    // The front of the list lives at the highest written slot, so position k is
    // slot length - 1 - k.
    assign top_slot   = count_reg - CW'(1);
    assign fetch_slot = count_reg - CW'(1) - CW'(in_pos);
    assign scan_slot  = count_reg - CW'(2) - cmp_reg;

    assign hit      = (ram_rdata == val_reg);
    assign last     = (cmp_reg == top_slot);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.list_length, out_reg.found_position,
                            out_reg.found, out_reg.match_count, out_reg.data_out,
                            out_reg.status};

    blss_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (LIST_DEPTH)
    ) u_values (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_val),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        cmp_next       = cmp_reg;
        mcnt_next      = mcnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_raddr      = top_slot[AW-1:0];

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = in_op;
                    val_next   = in_val;
                    cmp_next   = '0;
                    mcnt_next  = '0;
                    res_next   = '0;
                    state_next = S_RESULT;
                    case (in_op)
                        OP_PUSH:
                        begin
                            if (count_reg == CW'(LIST_DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = top_slot;
                                state_next = S_READ;
                            end
                        end
                        OP_COUNT, OP_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_FETCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else if (CMPW'(in_pos) >= CMPW'(count_reg))
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                ram_raddr  = fetch_slot[AW-1:0];
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_next.data_out = DATA_W'(ram_rdata);
                state_next        = S_RESULT;
            end
            S_SCAN:
            begin
                // The read data belongs to position cmp_reg; the next position is
                // requested in the same cycle.
                ram_raddr = scan_slot[AW-1:0];
                cmp_next  = cmp_reg + CW'(1);
                mcnt_next = mcnt_reg + CW'(hit);
                if (op_reg == OP_FIND)
                begin
                    if (hit)
                    begin
                        res_next.found          = 1'b1;
                        res_next.found_position = POS_W'(cmp_reg);
                        state_next              = S_RESULT;
                    end
                    else if (last)
                    begin
                        state_next = S_RESULT;
                    end
                end
                else if (last)
                begin
                    res_next.match_count = LEN_W'(mcnt_reg + CW'(hit));
                    state_next           = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_next             = res_reg;
                    out_next.list_length = LEN_W'(count_reg);
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        val_reg  <= val_next;
        cmp_reg  <= cmp_next;
        mcnt_reg <= mcnt_next;
        res_reg  <= res_next;
    end

    // The length never grows past the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(LIST_DEPTH))
        else $error("list length exceeds depth");

    // The length only moves right after an accepted request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(accept))
        else $error("list length changed without a request");

    // A scan never walks past the last entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cmp_reg < count_reg))
        else $error("scan position past the end of the list");

    // A new result is only posted from the result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg == S_RESULT))
        else $error("result posted outside the result state");

endmodule
